// File: sv/dcwb_pkg.sv
package dcwb_pkg;

    localparam int unsigned WORD_W = 36;
    localparam int unsigned STAT_W = 16;

    // status bit positions
    localparam int unsigned ST_PIA_LO   = 0;
    localparam int unsigned ST_PIA_HI   = 2;
    localparam int unsigned ST_PORT_LO  = 3;
    localparam int unsigned ST_PORT_HI  = 5;
    localparam int unsigned ST_DIR      = 8;
    localparam int unsigned ST_RQ       = 9;
    localparam int unsigned ST_AC       = 10;
    localparam int unsigned ST_MV       = 11;
    localparam int unsigned ST_CHARS_LO = 13;
    localparam int unsigned ST_CHARS_HI = 15;
    localparam int unsigned CTRL_W      = 13;

    typedef enum logic [2:0] {
        MODE_STATUS_RD = 3'd0,
        MODE_CTRL_WR   = 3'd1,
        MODE_BUF_RD    = 3'd2,
        MODE_BUF_WR    = 3'd3,
        MODE_DEV_RD    = 3'd4,
        MODE_DEV_WR    = 3'd5,
        MODE_CONNECT   = 3'd6,
        MODE_MOVE      = 3'd7
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [2:0]          unit_index;
        logic [2:0]          port;
        logic [WORD_W-1:0]   data_word;
        logic [2:0]          char_count;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]   read_data;
        logic                accepted;
        logic                irq_request;
        logic [2:0]          irq_level;
    } t_rsp;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [WORD_W-1:0]   cpu_buf;
        logic [WORD_W-1:0]   dev_acc;
        logic                irq;
    } t_unit;

endpackage

// File: sv/data_control_word_buffer.sv
// channel     direction  signals
// request in  in         i_req_valid, o_req_ready, i_req
// result out  out        o_rsp_valid, i_rsp_ready, o_rsp
//
// one request per cycle while results are taken; a request passes the input register, then the
// result register, with unit state updated at the edge that loads the result register
// reset (synchronous, active low) clears all unit status, words and interrupts
// a stalled result holds the result register; one more request waits in the input register

module data_control_word_buffer
    import dcwb_pkg::*;
#(
    parameter int unsigned NUM_UNITS = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int unsigned UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

    logic              r_s_valid;
    t_req              r_s_req;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [STAT_W-1:0] r_status [NUM_UNITS];
    logic [WORD_W-1:0] r_cpu_buf [NUM_UNITS];
    logic [WORD_W-1:0] r_dev_acc [NUM_UNITS];
    logic              r_irq [NUM_UNITS];

    logic              out_take;
    logic              fire;
    logic              in_range;
    logic [UW-1:0]     sel;
    t_unit             cur_unit;
    t_unit             new_unit;
    t_rsp              exec_rsp;
    t_rsp              n_out;

    assign out_take    = !r_out_valid || i_rsp_ready;
    assign fire        = r_s_valid && out_take;
    assign o_req_ready = !r_s_valid || out_take;
    assign in_range    = ({1'b0, r_s_req.unit_index} < 4'(NUM_UNITS));
    assign sel         = in_range ? r_s_req.unit_index[UW-1:0] : '0;

    assign cur_unit.status  = r_status[sel];
    assign cur_unit.cpu_buf = r_cpu_buf[sel];
    assign cur_unit.dev_acc = r_dev_acc[sel];
    assign cur_unit.irq     = r_irq[sel];

    dcwb_exec u_exec (
        .i_req  (r_s_req),
        .i_unit (cur_unit),
        .o_unit (new_unit),
        .o_rsp  (exec_rsp)
    );

    always_comb begin
        n_out = exec_rsp;
        if (!in_range) begin
            n_out.read_data   = r_s_req.data_word;
            n_out.accepted    = 1'b0;
            n_out.irq_request = 1'b0;
            n_out.irq_level   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_s_valid <= i_req_valid;
            end
            if (out_take) begin
                r_out_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_s_req <= i_req;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_UNITS; i++) begin
            if (!i_rst_n) begin
                r_status[i]  <= '0;
                r_cpu_buf[i] <= '0;
                r_dev_acc[i] <= '0;
                r_irq[i]     <= 1'b0;
            end else if (fire && in_range && (sel == UW'(i))) begin
                r_status[i]  <= new_unit.status;
                r_cpu_buf[i] <= new_unit.cpu_buf;
                r_dev_acc[i] <= new_unit.dev_acc;
                r_irq[i]     <= new_unit.irq;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !in_range) |=> (!o_rsp.accepted && !o_rsp.irq_request))
        else $error("out of range unit gave a result flag");

    a_irq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.irq_request) |-> (o_rsp.irq_level != 3'd0))
        else $error("interrupt raised on level zero");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !fire) |=> (r_s_valid && $stable(r_s_req)))
        else $error("input register lost a request under stall");

    a_status_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && in_range && (r_s_req.mode == MODE_STATUS_RD)) |=> o_rsp.accepted)
        else $error("status read not accepted");
`endif

endmodule

// File: sv/dcwb_exec.sv
module dcwb_exec
    import dcwb_pkg::*;
(
    input  t_req  i_req,
    input  t_unit i_unit,
    output t_unit o_unit,
    output t_rsp  o_rsp
);

    logic              port_ok;
    logic              dir;
    logic              ac_full;
    logic              rq;
    logic              mv;
    logic              pia_on;
    logic              acc;
    logic [WORD_W-1:0] rd;
    t_unit             nxt;

    assign port_ok = (i_unit.status[ST_PORT_HI:ST_PORT_LO] == i_req.port);
    assign dir     = i_unit.status[ST_DIR];
    assign ac_full = i_unit.status[ST_AC];
    assign rq      = i_unit.status[ST_RQ];
    assign mv      = i_unit.status[ST_MV];
    assign pia_on  = (i_unit.status[ST_PIA_HI:ST_PIA_LO] != 3'd0);

    always_comb begin
        nxt = i_unit;
        rd  = i_req.data_word;
        acc = 1'b0;
        case (i_req.mode)
            MODE_STATUS_RD: begin
                rd  = {{(WORD_W-STAT_W){1'b0}}, i_unit.status};
                acc = 1'b1;
            end
            MODE_CTRL_WR: begin
                nxt.status = {{(STAT_W-CTRL_W){1'b0}}, i_req.data_word[CTRL_W-1:0]};
                nxt.irq    = i_req.data_word[ST_RQ]
                             && (i_req.data_word[ST_PIA_HI:ST_PIA_LO] != 3'd0);
                acc        = 1'b1;
            end
            MODE_BUF_RD, MODE_BUF_WR: begin
                nxt.irq = 1'b0;
                if (rq) begin
                    if (i_req.mode == MODE_BUF_RD) begin
                        rd = i_unit.cpu_buf;
                    end else begin
                        nxt.cpu_buf = i_req.data_word;
                    end
                    nxt.status[ST_RQ] = 1'b0;
                    nxt.status[ST_MV] = 1'b1;
                    acc               = 1'b1;
                end
            end
            MODE_DEV_RD, MODE_DEV_WR: begin
                if (port_ok && !ac_full && (dir == (i_req.mode == MODE_DEV_RD))) begin
                    if (i_req.mode == MODE_DEV_RD) begin
                        rd = i_unit.dev_acc;
                    end else begin
                        nxt.dev_acc = i_req.data_word;
                    end
                    nxt.status[ST_CHARS_HI:ST_CHARS_LO] = i_req.char_count;
                    nxt.status[ST_AC]                   = 1'b1;
                    nxt.status[ST_MV]                   = 1'b1;
                    acc                                 = 1'b1;
                end
            end
            MODE_CONNECT: begin
                acc = port_ok && !(dir && ac_full);
            end
            MODE_MOVE: begin
                if (mv && ac_full && !rq) begin
                    if (dir) begin
                        nxt.dev_acc = i_unit.cpu_buf;
                    end else begin
                        nxt.cpu_buf = i_unit.dev_acc;
                    end
                    nxt.status[ST_MV] = 1'b0;
                    nxt.status[ST_AC] = 1'b0;
                    nxt.status[ST_RQ] = 1'b1;
                    acc               = 1'b1;
                end
                if (nxt.status[ST_RQ] && pia_on) begin
                    nxt.irq = 1'b1;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    assign o_unit            = nxt;
    assign o_rsp.read_data   = rd;
    assign o_rsp.accepted    = acc;
    assign o_rsp.irq_request = nxt.irq;
    assign o_rsp.irq_level   = nxt.status[ST_PIA_HI:ST_PIA_LO];

endmodule
